// ===== hdl/mceu_pkg.sv =====
package mceu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned IpW   = 11;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned RegAw = 2;
  localparam int unsigned RegCnt = 4;

  // Instruction space bound; the pointer saturates at the top of its range.
  localparam logic [IpW-1:0] CodeDepth = 11'd1024;
  localparam logic [IpW-1:0] IpMax     = 11'h7FF;

  typedef enum logic [2:0] {
    MODE_MOV,
    MODE_ADD,
    MODE_CMP,
    MODE_JMP,
    MODE_JZ,
    MODE_JNZ,
    MODE_HALT,
    MODE_LOAD
  } mode_e;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_DIRECT,
    SRC_INDIRECT,
    SRC_IMM
  } src_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DATA_ADDR,
    ST_CODE_RANGE
  } status_e;

  typedef enum logic {
    REG_DATA_SIZE,
    REG_CODE_SIZE
  } cfg_reg_e;

  typedef struct packed {
    mode_e                   mode;
    logic [RegAw-1:0]        dest_reg;
    src_kind_e               src_kind;
    logic [RegAw-1:0]        src_reg;
    logic signed [WordW-1:0] src_value;
    logic [IpW-1:0]          target;
  } in_item_t;

  typedef struct packed {
    logic [IpW-1:0]          next_ip;
    logic                    zero_flag;
    logic                    sign_flag;
    logic signed [WordW-1:0] dest_value;
    status_e                 status;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] idx;
    logic [WordW-1:0] data;
  } reg_wr_t;

endpackage

// ===== hdl/mceu_ram.sv =====
module mceu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mini_cpu_execute_unit_top.sv =====
// Execute unit of a four-register machine. One word per clock is accepted while in_stall_o
// is low, and one result word is returned per input word, in order, from the output
// register. The register file sits in a pair of 4-entry memories read at acceptance, with
// one valid bit per register so that it reads as zero after reset, and the data segment in
// a DATA_DEPTH-word memory read and written as a word leaves stage 1; results of the
// instruction ahead are forwarded into the first stage, so dependent instructions issue
// back to back. A full stall of the output fills the three stages before the input stalls.
// Preload words (mode 7) fill the data segment; reading a never-written word gives an
// undefined value. data_size and code_size are written over the APB port at 0x0 and 0x4.
module mini_cpu_execute_unit_top #(
  parameter int unsigned DATA_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mceu_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mceu_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import mceu_pkg::*;

  localparam int unsigned DataAw = $clog2(DATA_DEPTH);

  // Configuration
  logic [CfgW-1:0] data_size_q, code_size_q;
  logic            cfg_wr;
  cfg_reg_e        cfg_sel;

  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q <= '0;
      code_size_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DATA_SIZE: data_size_q <= pwdata[CfgW-1:0];
        REG_CODE_SIZE: code_size_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DATA_SIZE: prdata = 32'(data_size_q);
      REG_CODE_SIZE: prdata = 32'(code_size_q);
      default:       prdata = '0;
    endcase
  end

  // Pipeline control
  logic      s1_valid_q, s2_valid_q, out_valid_q;
  in_item_t  s1_item_q, s2_item_q;
  out_item_t out_q, s2_out;
  logic      out_free, s2_free, s1_free, s1_adv, s2_adv, in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  // Register file: one copy per read port, written together
  reg_wr_t           s2_wr, wb_q;
  logic [WordW-1:0]  rf_src_rdata, rf_dst_rdata;
  logic              rf_we;
  logic [RegCnt-1:0] rf_vld_q;
  logic              rf_src_vld_q, rf_dst_vld_q;

  assign rf_we = s2_wr.en && s2_adv;

  mceu_ram #(.Width(WordW), .Depth(RegCnt)) u_rf_src (
    .clk_i,
    .we_i    (rf_we),
    .waddr_i (s2_wr.idx),
    .wdata_i (s2_wr.data),
    .re_i    (in_acc),
    .raddr_i (in_data_i.src_reg),
    .rdata_o (rf_src_rdata)
  );

  mceu_ram #(.Width(WordW), .Depth(RegCnt)) u_rf_dst (
    .clk_i,
    .we_i    (rf_we),
    .waddr_i (s2_wr.idx),
    .wdata_i (s2_wr.data),
    .re_i    (in_acc),
    .raddr_i (in_data_i.dest_reg),
    .rdata_o (rf_dst_rdata)
  );

  // Last register write, covers a read issued at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q         <= '0;
      rf_vld_q     <= '0;
      rf_src_vld_q <= 1'b0;
      rf_dst_vld_q <= 1'b0;
    end else begin
      if (rf_we) begin
        wb_q                <= s2_wr;
        rf_vld_q[s2_wr.idx] <= 1'b1;
      end
      // Sample with the read so a register never written reads as zero
      if (in_acc) begin
        rf_src_vld_q <= rf_vld_q[in_data_i.src_reg];
        rf_dst_vld_q <= rf_vld_q[in_data_i.dest_reg];
      end
    end
  end

  // Stage 1: resolve register operands, form data address
  logic [WordW-1:0] s1_src_val, s1_dst_val, s1_addr;
  logic             s1_addr_ok, s1_need_read, s1_is_load, s1_bad;

  always_comb begin
    if (s2_wr.en && s2_wr.idx == s1_item_q.src_reg) begin
      s1_src_val = s2_wr.data;
    end else if (wb_q.en && wb_q.idx == s1_item_q.src_reg) begin
      s1_src_val = wb_q.data;
    end else begin
      s1_src_val = rf_src_vld_q ? rf_src_rdata : '0;
    end
    if (s2_wr.en && s2_wr.idx == s1_item_q.dest_reg) begin
      s1_dst_val = s2_wr.data;
    end else if (wb_q.en && wb_q.idx == s1_item_q.dest_reg) begin
      s1_dst_val = wb_q.data;
    end else begin
      s1_dst_val = rf_dst_vld_q ? rf_dst_rdata : '0;
    end
  end

  assign s1_is_load   = (s1_item_q.mode == MODE_LOAD);
  assign s1_need_read = (s1_item_q.mode == MODE_MOV || s1_item_q.mode == MODE_ADD ||
                         s1_item_q.mode == MODE_CMP) &&
                        (s1_item_q.src_kind == SRC_DIRECT ||
                         s1_item_q.src_kind == SRC_INDIRECT);

  always_comb begin
    if (s1_is_load) begin
      s1_addr = WordW'(s1_item_q.target);
    end else if (s1_item_q.src_kind == SRC_DIRECT) begin
      s1_addr = s1_item_q.src_value;
    end else begin
      s1_addr = s1_src_val;
    end
  end

  assign s1_addr_ok = !s1_addr[WordW-1] && (s1_addr < WordW'(data_size_q)) &&
                      (s1_addr < WordW'(DATA_DEPTH));
  assign s1_bad     = (s1_is_load || s1_need_read) && !s1_addr_ok;

  // Data segment: reads and preload writes both happen as a word leaves stage 1
  logic [WordW-1:0] dm_rdata;

  mceu_ram #(.Width(WordW), .Depth(DATA_DEPTH)) u_dmem (
    .clk_i,
    .we_i    (s1_adv && s1_is_load && s1_addr_ok),
    .waddr_i (s1_addr[DataAw-1:0]),
    .wdata_i (s1_item_q.src_value),
    .re_i    (s1_adv && s1_need_read && s1_addr_ok),
    .raddr_i (s1_addr[DataAw-1:0]),
    .rdata_o (dm_rdata)
  );

  // Stage 2 operands
  logic [WordW-1:0] s2_dst_q, s2_src_q;
  logic             s2_from_mem_q, s2_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      s2_item_q     <= s1_item_q;
      s2_dst_q      <= s1_dst_val;
      s2_src_q      <= (s1_item_q.src_kind == SRC_IMM) ? s1_item_q.src_value : s1_src_val;
      s2_from_mem_q <= s1_need_read;
      s2_bad_q      <= s1_bad;
    end
    if (s2_adv) begin
      out_q <= s2_out;
    end
  end

  // Stage 2: execute, update pointer and flags
  logic [IpW-1:0]   ip_q, ip_d, nip, bound;
  logic             zf_q, zf_d, sf_q, sf_d;
  logic [WordW-1:0] src, sum;
  status_e          status;

  assign bound = (code_size_q < CodeDepth) ? code_size_q : CodeDepth;
  assign src   = s2_from_mem_q ? dm_rdata : s2_src_q;
  assign sum   = s2_dst_q + src;

  always_comb begin
    ip_d        = ip_q;
    zf_d        = zf_q;
    sf_d        = sf_q;
    s2_wr.en    = 1'b0;
    s2_wr.idx   = s2_item_q.dest_reg;
    s2_wr.data  = src;
    status      = ST_OK;
    nip         = (ip_q == IpMax) ? IpMax : ip_q + 1'b1;
    unique case (s2_item_q.mode)
      MODE_MOV: s2_wr.en = !s2_bad_q;
      MODE_ADD: begin
        s2_wr.en   = !s2_bad_q;
        s2_wr.data = sum;
      end
      MODE_CMP: begin
        if (!s2_bad_q) begin
          sf_d = $signed(s2_dst_q) < $signed(src);
          zf_d = (s2_dst_q == src);
        end
      end
      MODE_JMP:  nip = s2_item_q.target;
      MODE_JZ:   nip = zf_q ? s2_item_q.target : nip;
      MODE_JNZ:  nip = zf_q ? nip : s2_item_q.target;
      MODE_HALT: nip = bound;
      default: ;
    endcase
    if (s2_bad_q) begin
      status = ST_DATA_ADDR;
    end else if (s2_item_q.mode != MODE_LOAD) begin
      ip_d = nip;
      if (nip > bound) begin
        status = ST_CODE_RANGE;
      end
    end
    s2_wr.en = s2_wr.en && s2_valid_q;
  end

  always_comb begin
    s2_out.next_ip    = ip_d;
    s2_out.zero_flag  = zf_d;
    s2_out.sign_flag  = sf_d;
    s2_out.dest_value = s2_wr.en ? s2_wr.data : s2_dst_q;
    s2_out.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q <= '0;
      zf_q <= 1'b0;
      sf_q <= 1'b0;
    end else if (s2_adv) begin
      ip_q <= ip_d;
      zf_q <= zf_d;
      sf_q <= sf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
